// File: hdl/ccfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccfp_pkg
// Shared types, constants and the CRC-32 lookup table for the frame parser.
// ----------------------------------------------------------------------------
package ccfp_pkg;

	localparam int unsigned POSITION_BITS_DEF = 16;

	localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
	localparam logic [7:0]  MAGIC0    = 8'h42;
	localparam logic [7:0]  MAGIC1    = 8'h45;
	localparam logic [7:0]  MARKER    = 8'hFF;
	localparam logic [7:0]  LOGIN_OK  = 8'h01;
	localparam logic [7:0]  ZERO_BYTE = 8'h00;

	localparam logic [7:0]  TYPE_LOGIN   = 8'h00;
	localparam logic [7:0]  TYPE_COMMAND = 8'h01;
	localparam logic [7:0]  TYPE_MESSAGE = 8'h02;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_TOO_SHORT = 3'd1,
		ST_BAD_MAGIC = 3'd2,
		ST_BAD_MARK  = 3'd3,
		ST_CRC_BAD   = 3'd4,
		ST_EMPTY     = 3'd5
	} status_t;

	typedef struct packed {
		status_t    status;
		logic [7:0] packet_type;
		logic       seq_present;
		logic [7:0] sequence_res;
		logic       success_present;
		logic       login_ok;
		logic       multi_part;
		logic [7:0] total_parts;
		logic [7:0] part_index;
	} summary_t;

	typedef logic [31:0] crc_table_t [256];

	function automatic crc_table_t gen_crc_table();
		crc_table_t tbl;
		logic [31:0] c;
		for (int i = 0; i < 256; i++) begin
			c = 32'(i);
			for (int k = 0; k < 8; k++) begin
				c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
			end
			tbl[i] = c;
		end
		return tbl;
	endfunction

	localparam crc_table_t CRC_TABLE = gen_crc_table();

endpackage

// File: hdl/ccfp_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccfp stream interfaces
// Valid/ready channels for received bytes and for parser results.
// ----------------------------------------------------------------------------
interface ccfp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       end_of_datagram;

	modport source (output valid, output rx_byte, output end_of_datagram, input ready);
	modport sink   (input valid, input rx_byte, input end_of_datagram, output ready);
endinterface

interface ccfp_res_if;
	logic       valid;
	logic       ready;
	logic       item_kind;
	logic [7:0] body_byte;
	logic [2:0] status;
	logic [7:0] packet_type;
	logic       seq_present;
	logic [7:0] sequence_res;
	logic       success_present;
	logic       login_ok;
	logic       multi_part;
	logic [7:0] total_parts;
	logic [7:0] part_index;
	logic       run_last;

	modport source (
		output valid, output item_kind, output body_byte, output status,
		output packet_type, output seq_present, output sequence_res,
		output success_present, output login_ok, output multi_part,
		output total_parts, output part_index, output run_last,
		input ready
	);
	modport sink (
		input valid, input item_kind, input body_byte, input status,
		input packet_type, input seq_present, input sequence_res,
		input success_present, input login_ok, input multi_part,
		input total_parts, input part_index, input run_last,
		output ready
	);
endinterface

// File: hdl/crc32_checked_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc32_checked_frame_parser
// Each byte is registered in the input stage, and its results in the result group.
// Throughput: one byte per cycle, but a byte with results waits until earlier
// results are taken; a byte yields 0 to 3 results, one per cycle on the result port while ready is high.
// Reset: asynchronous, clears the input stage and result group valid flags,
// the result index and the per-datagram state; the held multi-part bytes are not cleared.
// ----------------------------------------------------------------------------
module crc32_checked_frame_parser #(
	parameter int unsigned POSITION_BITS = ccfp_pkg::POSITION_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	ccfp_rx_if.sink        rx,
	ccfp_res_if.source     res
);
	import ccfp_pkg::*;

	localparam int unsigned PB = POSITION_BITS;

	// input stage
	logic          s1_valid_q;
	logic [7:0]    byte_s1;
	logic          last_s1;

	// per-datagram state
	logic [PB-1:0] pos_q;
	logic [31:0]   crc_q;
	logic [31:0]   rcrc_q;
	status_t       herr_q;
	logic [7:0]    type_q;
	logic [7:0]    seq_q;
	logic [7:0]    held_q [3];

	// result group
	logic          grp_valid_q;
	logic [1:0]    grp_idx_q;
	logic [1:0]    grp_last_q;
	logic          grp_sum_q;
	logic [7:0]    grp_data_q [2];
	summary_t      grp_rec_q;

	// next-state logic
	logic [PB-1:0] p;
	logic [7:0]    b;
	logic [31:0]   crc_upd;
	logic [31:0]   crc_n;
	logic [31:0]   rcrc_n;
	status_t       herr_n;
	logic [7:0]    type_n;
	logic [7:0]    seq_n;
	logic [7:0]    held_n [3];
	logic          in_pay;
	logic          is_cmd;
	logic          is_msg;
	logic          emit;
	logic          flush;
	logic [1:0]    dcnt;
	logic [1:0]    res_n;
	status_t       st;
	summary_t      rec;
	logic          grp_done;
	logic          proc;

	assign p = pos_q;
	assign b = byte_s1;

	always_comb begin
		herr_n = herr_q;
		if (herr_q == ST_OK) begin
			priority if (p == PB'(0) && b != MAGIC0) herr_n = ST_BAD_MAGIC;
			else if (p == PB'(1) && b != MAGIC1) herr_n = ST_BAD_MAGIC;
			else if (p == PB'(6) && b != MARKER) herr_n = ST_BAD_MARK;
			else herr_n = herr_q;
		end
	end

	always_comb begin
		rcrc_n = rcrc_q;
		for (int k = 0; k < 4; k++) begin
			if (p == PB'(2 + k)) rcrc_n[8*k +: 8] = b;
		end
	end

	assign in_pay  = p >= PB'(7);
	assign crc_upd = (crc_q >> 8) ^ CRC_TABLE[crc_q[7:0] ^ b];
	assign crc_n   = in_pay ? crc_upd : crc_q;
	assign type_n  = (p == PB'(7)) ? b : type_q;
	assign seq_n   = (p == PB'(8)) ? b : seq_q;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			held_n[k] = (p == PB'(9 + k)) ? b : held_q[k];
		end
	end

	assign is_cmd = type_n == TYPE_COMMAND;
	assign is_msg = type_n == TYPE_MESSAGE;

	always_comb begin
		emit = 1'b0;
		if (herr_n == ST_OK && p >= PB'(9)) begin
			priority if (is_msg) emit = 1'b1;
			else if (is_cmd) begin
				priority if (p == PB'(9)) emit = b != ZERO_BYTE;
				else if (p <= PB'(11)) emit = held_n[0] != ZERO_BYTE;
				else emit = 1'b1;
			end
			else emit = 1'b0;
		end
	end

	assign flush = last_s1 && herr_n == ST_OK && is_cmd && held_n[0] == ZERO_BYTE
		&& (p == PB'(9) || p == PB'(10));

	always_comb begin
		priority if (flush) dcnt = (p == PB'(9)) ? 2'd1 : 2'd2;
		else if (emit) dcnt = 2'd1;
		else dcnt = 2'd0;
	end

	assign res_n = dcnt + {1'b0, last_s1};

	always_comb begin
		priority if (p < PB'(6)) st = ST_TOO_SHORT;
		else if (herr_n != ST_OK) st = herr_n;
		else if ((crc_n ^ CRC_INIT) != rcrc_n) st = ST_CRC_BAD;
		else if (p < PB'(7)) st = ST_EMPTY;
		else st = ST_OK;
	end

	always_comb begin
		rec = '0;
		rec.status = st;
		if (st == ST_OK) begin
			rec.packet_type     = type_n;
			rec.seq_present     = (is_cmd || is_msg) && p >= PB'(8);
			rec.sequence_res    = rec.seq_present ? seq_n : 8'h00;
			rec.success_present = type_n == TYPE_LOGIN && p >= PB'(8);
			rec.login_ok        = rec.success_present && seq_n == LOGIN_OK;
			rec.multi_part      = is_cmd && p >= PB'(11) && held_n[0] == ZERO_BYTE;
			rec.total_parts     = rec.multi_part ? held_n[1] : 8'h00;
			rec.part_index      = rec.multi_part ? held_n[2] : 8'h00;
		end
	end

	assign grp_done = grp_valid_q && res.ready && grp_idx_q == grp_last_q;
	assign proc     = s1_valid_q && (res_n == 2'd0 || !grp_valid_q || grp_done);
	assign rx.ready = !s1_valid_q || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (rx.ready) begin
			s1_valid_q <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
			last_s1 <= rx.end_of_datagram;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			crc_q  <= CRC_INIT;
			rcrc_q <= '0;
			herr_q <= ST_OK;
			type_q <= '0;
			seq_q  <= '0;
		end else if (proc) begin
			if (last_s1) begin
				pos_q  <= '0;
				crc_q  <= CRC_INIT;
				rcrc_q <= '0;
				herr_q <= ST_OK;
				type_q <= '0;
				seq_q  <= '0;
			end else begin
				pos_q  <= (p != '1) ? p + PB'(1) : p;
				crc_q  <= crc_n;
				rcrc_q <= rcrc_n;
				herr_q <= herr_n;
				type_q <= type_n;
				seq_q  <= seq_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			held_q <= held_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_valid_q <= 1'b0;
			grp_idx_q   <= '0;
		end else if (proc && res_n != 2'd0) begin
			grp_valid_q <= 1'b1;
			grp_idx_q   <= '0;
		end else if (grp_done) begin
			grp_valid_q <= 1'b0;
		end else if (grp_valid_q && res.ready) begin
			grp_idx_q <= grp_idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && res_n != 2'd0) begin
			grp_last_q    <= res_n - 2'd1;
			grp_sum_q     <= last_s1;
			grp_data_q[0] <= flush ? held_n[0] : b;
			grp_data_q[1] <= held_n[1];
			grp_rec_q     <= rec;
		end
	end

	logic     out_sum;
	summary_t out_rec;

	assign out_sum = grp_sum_q && grp_idx_q == grp_last_q;
	assign out_rec = out_sum ? grp_rec_q : '0;

	assign res.valid           = grp_valid_q;
	assign res.item_kind       = out_sum;
	assign res.body_byte       = out_sum ? 8'h00 : grp_data_q[grp_idx_q[0]];
	assign res.status          = out_rec.status;
	assign res.packet_type     = out_rec.packet_type;
	assign res.seq_present     = out_rec.seq_present;
	assign res.sequence_res    = out_rec.sequence_res;
	assign res.success_present = out_rec.success_present;
	assign res.login_ok        = out_rec.login_ok;
	assign res.multi_part      = out_rec.multi_part;
	assign res.total_parts     = out_rec.total_parts;
	assign res.part_index      = out_rec.part_index;
	assign res.run_last        = grp_idx_q == grp_last_q;

endmodule
